// File: hw/rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared payload types, pipeline stage types and constants for the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

   localparam int HueWidth  = 16;
   localparam int ChanWidth = 8;

   // Half of one hue period (hue * 6 spans three periods of 2^17).
   localparam logic [16:0] HALF_PERIOD = 17'd65536;
   // Added before the shift that takes the ceiling of a division by 2^16.
   localparam logic [15:0] CEIL_FRAC   = 16'd65535;
   // Added before a floor division by 255 to turn it into a ceiling.
   localparam logic [15:0] CEIL_255    = 16'd254;
   // Reciprocal of 255 in 16-bit fixed point, rounded down.
   localparam logic [8:0]  RECIP_255   = 9'd257;
   localparam logic [15:0] CHAN_MAX    = 16'd255;

   typedef struct packed {
      logic [HueWidth-1:0]  hue;
      logic [ChanWidth-1:0] saturation;
      logic [ChanWidth-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rsp_type;

   // Six 60-degree sectors of the hue circle.
   typedef enum logic [2:0] {
      SECT_RED_YELLOW     = 3'd0,
      SECT_YELLOW_GREEN   = 3'd1,
      SECT_GREEN_CYAN     = 3'd2,
      SECT_CYAN_BLUE      = 3'd3,
      SECT_BLUE_MAGENTA   = 3'd4,
      SECT_MAGENTA_RED    = 3'd5
   } sector_type;

   // What the front end hands to the divide stages.
   typedef struct packed {
      sector_type           sector;
      logic [ChanWidth-1:0] value;
      logic [15:0]          chroma;    // saturation * brightness
      logic [31:0]          weighted;  // chroma * hue distance
   } stage_type;

endpackage : hsv_pkg

`default_nettype wire

// File: hw/rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// HSV front end
// Two register stages: sector, hue distance and chroma first, then the
// product of chroma and hue distance.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front
   import hsv_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire req_type   in_data,
   output logic           out_valid,
   output stage_type      out_stage
);

   logic [18:0]   scaled;
   logic [16:0]   phase;
   logic [16:0]   dist_in;
   logic          v1_ff;
   sector_type    sector1_ff;
   logic [16:0]   dist1_ff;
   logic [15:0]   chroma1_ff;
   logic [7:0]    value1_ff;
   logic          v2_ff;
   stage_type     stage2_ff;
   stage_type     stage2_in;

   // hue * 6 by shifts; the top three bits are the sector.
   assign scaled = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};
   assign phase  = scaled[16:0];

   always_comb begin
      if (phase[16]) begin
         dist_in = phase - HALF_PERIOD;
      end else begin
         dist_in = HALF_PERIOD - phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      sector1_ff <= sector_type'(scaled[18:16]);
      dist1_ff   <= dist_in;
      chroma1_ff <= 16'(in_data.saturation) * 16'(in_data.brightness);
      value1_ff  <= in_data.brightness;
   end

   always_comb begin
      stage2_in.sector   = sector1_ff;
      stage2_in.value    = value1_ff;
      stage2_in.chroma   = chroma1_ff;
      stage2_in.weighted = 32'({16'd0, chroma1_ff} * {15'd0, dist1_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      stage2_ff <= stage2_in;
   end

   assign out_valid = v2_ff;
   assign out_stage = stage2_ff;

endmodule : hsv_front

`default_nettype wire

// File: hw/rtl/hsv_div255.sv
// ----------------------------------------------------------------------------
// Divide by 255
// Two-stage floor division of a 16-bit value (at most 65279) by 255, done as
// a multiply by the reciprocal and one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_div255
   import hsv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [15:0] in_value,
   output logic             out_valid,
   output logic [7:0]       out_quot
);

   logic          va_ff;
   logic [15:0]   num_ff;
   logic [23:0]   prod_ff;
   logic [7:0]    est;
   logic [15:0]   rem;
   logic [7:0]    quot_in;
   logic          vb_ff;
   logic [7:0]    quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      num_ff  <= in_value;
      prod_ff <= 24'({9'd0, in_value} * {16'd0, RECIP_255});
   end

   // The estimate is never high and at most one low over this input range.
   always_comb begin
      est = prod_ff[23:16];
      rem = num_ff - ({est, 8'd0} - {8'd0, est});
      if (rem >= CHAN_MAX) begin
         quot_in = est + 8'd1;
      end else begin
         quot_in = est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      quot_ff <= quot_in;
   end

   assign out_valid = vb_ff;
   assign out_quot  = quot_ff;

endmodule : hsv_div255

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-sector HSV to RGB conversion in fixed point, pipelined for one color
// per clock.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Handshake
//  request   start, busy, req_data         transfer when start && !busy
//  response  rsp_strobe, rsp_data          one-cycle strobe, no back pressure
//
//  A request transfer reaches the response ports through the stages listed below.
//  One color may enter on every clock; busy is always low.
//  The five stages are: sector and chroma, chroma times hue distance,
//  reciprocal multiply for both divisions by 255, correction, channel select.
//  Synchronous reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic          front_valid;
   stage_type     front_stage;
   logic [32:0]   weighted_up;
   logic [15:0]   num_x;
   logic [15:0]   num_z;
   logic          x_valid;
   logic          z_valid;
   logic [7:0]    quot_x;
   logic [7:0]    quot_z;
   sector_type    sector_a_ff;
   sector_type    sector_b_ff;
   logic [7:0]    value_a_ff;
   logic [7:0]    value_b_ff;
   logic [7:0]    comp_x;
   logic [7:0]    comp_z;
   rsp_type       rsp_in;
   rsp_type       rsp_ff;
   logic          strobe_ff;

   assign busy = 1'b0;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_stage (front_stage)
   );

   // Ceiling of the weighted chroma over 2^16, then ceiling over 255 below.
   assign weighted_up = {1'b0, front_stage.weighted} + {17'd0, CEIL_FRAC};
   assign num_x = weighted_up[31:16] + CEIL_255;
   assign num_z = front_stage.chroma + CEIL_255;

   hsv_div255 u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_value  (num_x),
      .out_valid (x_valid),
      .out_quot  (quot_x)
   );

   hsv_div255 u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_value  (num_z),
      .out_valid (z_valid),
      .out_quot  (quot_z)
   );

   always_ff @(posedge clock) begin
      sector_a_ff <= front_stage.sector;
      sector_b_ff <= sector_a_ff;
      value_a_ff  <= front_stage.value;
      value_b_ff  <= value_a_ff;
   end

   assign comp_x = value_b_ff - quot_x;
   assign comp_z = value_b_ff - quot_z;

   always_comb begin
      unique case (sector_b_ff)
         SECT_RED_YELLOW: begin
            rsp_in = '{red: value_b_ff, green: comp_x, blue: comp_z};
         end
         SECT_YELLOW_GREEN: begin
            rsp_in = '{red: comp_x, green: value_b_ff, blue: comp_z};
         end
         SECT_GREEN_CYAN: begin
            rsp_in = '{red: comp_z, green: value_b_ff, blue: comp_x};
         end
         SECT_CYAN_BLUE: begin
            rsp_in = '{red: comp_z, green: comp_x, blue: value_b_ff};
         end
         SECT_BLUE_MAGENTA: begin
            rsp_in = '{red: comp_x, green: comp_z, blue: value_b_ff};
         end
         default: begin
            rsp_in = '{red: value_b_ff, green: comp_z, blue: comp_x};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= x_valid & z_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule : hsv_to_rgb_converter

`default_nettype wire

// File: hw/rtl/hsv_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the converter's ports for latency, grey and black behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_checker
   import hsv_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // Every transfer comes back as a response strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("request transfer without a response five cycles later");

   // No response appears without a matching earlier request transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, 5))
      else $error("response without a matching request transfer");

   // Zero saturation gives grey at the requested brightness.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.saturation == 8'd0) |-> ##5
         (rsp_data.red == $past(req_data.brightness, 5) &&
          rsp_data.green == $past(req_data.brightness, 5) &&
          rsp_data.blue == $past(req_data.brightness, 5)))
      else $error("zero saturation did not give grey");

   // Zero brightness gives black.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.brightness == 8'd0) |-> ##5
         (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0))
      else $error("zero brightness did not give black");

endmodule : hsv_checker

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
